/* hw/rtl/blg_pkg.sv */
// Shared types for the Bresenham line generator unit.
// Holds the command kind and the control word that travels from the front end to the back end.
// No dependencies.
package blg_pkg;

  // Kind of an input word, as carried on the slave tuser bit.
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } blg_op_e;

  // Control part of a queued command; the coordinate payload travels beside it.
  typedef struct packed {
    blg_op_e op;
    logic    y_step_down;
  } blg_cmd_ctl_t;

endpackage

/* hw/rtl/blg_front.sv */
// Front end of the line generator: takes input words and classifies them.
// A start word has its endpoints ordered left to right and its deltas worked out here.
// Depends on blg_pkg.
module blg_front #(
  parameter int COORD_BITS = 8,
  parameter int IN_W       = 48,
  parameter int DATA_W     = 64
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_W-1:0]      s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output blg_pkg::blg_cmd_ctl_t ctl_o,
  output logic [DATA_W-1:0]    data_o
);
  import blg_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB-1:0] sx, sy, fx, fy;
  logic [CB-1:0] x0, y0, x1, y1, dx, dy;
  logic [15:0]   color;
  logic          swap, down;

  assign sx    = s_axis_tdata_i[CB-1:0];
  assign sy    = s_axis_tdata_i[2*CB-1:CB];
  assign fx    = s_axis_tdata_i[3*CB-1:2*CB];
  assign fy    = s_axis_tdata_i[4*CB-1:3*CB];
  assign color = s_axis_tdata_i[4*CB+15:4*CB];

  always_comb begin
    swap = sx > fx;
    x0   = swap ? fx : sx;
    y0   = swap ? fy : sy;
    x1   = swap ? sx : fx;
    y1   = swap ? sy : fy;
    dx   = x1 - x0;
    down = y1 < y0;
    dy   = down ? (y0 - y1) : (y1 - y0);
  end

  assign s_axis_tready_o   = !fifo_full_i;
  assign push_o            = s_axis_tvalid_i && !fifo_full_i;
  assign ctl_o.op          = blg_op_e'(s_axis_tuser_i);
  assign ctl_o.y_step_down = down;
  // The payload of an advance word is never looked at by the back end.
  assign data_o            = {color, dy, dx, y1, x1, y0, x0};

endmodule

/* hw/rtl/blg_cmd_fifo.sv */
// Short command queue between the front end and the back end of the line generator.
// Register based, first word out at the head; no dependencies beyond the parameters.
// Depends on nothing else.
module blg_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == FULL_CNT;
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("command queue holds more words than it has entries");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("front end pushed into a full command queue");

endmodule

/* hw/rtl/blg_back.sv */
// Back end of the line generator: holds the line state and walks it at most one pixel per command.
// The current pixel registers double as the output register of the master side.
// Depends on blg_pkg.
module blg_back #(
  parameter int COORD_BITS = 8,
  parameter int DATA_W     = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  blg_pkg::blg_cmd_ctl_t cmd_ctl_i,
  input  logic [DATA_W-1:0]     cmd_data_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [15:0]           pixel_color_o,
  output logic                  last_o
);
  import blg_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int ERR_W = CB + 3;
  localparam int TW_W  = CB + 4;

  logic [CB-1:0]          cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CB-1:0]          end_x_q, end_x_d, end_y_q, end_y_d;
  logic [CB-1:0]          dx_q, dx_d;
  logic signed [CB:0]     ndy_q, ndy_d;
  logic                   down_q, down_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [15:0]            color_q, color_d;
  logic                   active_q, active_d;
  logic                   out_valid_q, out_valid_d;
  logic                   last_q, last_d;

  logic [CB-1:0]          c_x0, c_y0, c_x1, c_y1, c_dx, c_dy;
  logic [15:0]            c_color;
  logic signed [TW_W-1:0] twice, ndy_ext, dx_ext, err_sum;
  logic                   step_x, step_y, emit, fin, can_issue;

  assign c_x0    = cmd_data_i[CB-1:0];
  assign c_y0    = cmd_data_i[2*CB-1:CB];
  assign c_x1    = cmd_data_i[3*CB-1:2*CB];
  assign c_y1    = cmd_data_i[4*CB-1:3*CB];
  assign c_dx    = cmd_data_i[5*CB-1:4*CB];
  assign c_dy    = cmd_data_i[6*CB-1:5*CB];
  assign c_color = cmd_data_i[6*CB+15:6*CB];

  // A command is taken only when the pixel register is free or being emptied.
  assign can_issue = !out_valid_q || out_ready_i;
  assign cmd_pop_o = !cmd_empty_i && can_issue;

  // One Bresenham step: the doubled error is compared with both deltas.
  always_comb begin
    twice   = $signed({err_q[ERR_W-1], err_q[ERR_W-1:0]}) <<< 1;
    ndy_ext = TW_W'(ndy_q);
    dx_ext  = $signed({4'b0000, dx_q});
    step_x  = twice >= ndy_ext;
    step_y  = twice <= dx_ext;
    err_sum = $signed({err_q[ERR_W-1], err_q})
              + (step_x ? ndy_ext : '0)
              + (step_y ? dx_ext : '0);
  end

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    end_x_d = end_x_q;
    end_y_d = end_y_q;
    dx_d    = dx_q;
    ndy_d   = ndy_q;
    down_d  = down_q;
    err_d   = err_q;
    color_d = color_q;
    emit    = 1'b0;
    case (cmd_ctl_i.op)
      OP_START: begin
        cur_x_d = c_x0;
        cur_y_d = c_y0;
        end_x_d = c_x1;
        end_y_d = c_y1;
        dx_d    = c_dx;
        ndy_d   = -$signed({1'b0, c_dy});
        down_d  = cmd_ctl_i.y_step_down;
        err_d   = $signed({3'b000, c_dx}) - $signed({3'b000, c_dy});
        color_d = c_color;
        emit    = 1'b1;
      end
      OP_ADVANCE: begin
        if (active_q) begin
          if (step_x) begin
            cur_x_d = cur_x_q + 1'b1;
          end
          if (step_y) begin
            cur_y_d = down_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
          end
          err_d = err_sum[ERR_W-1:0];
          emit  = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    fin      = (cur_x_d == end_x_d) && (cur_y_d == end_y_d);
    active_d = emit ? !fin : active_q;
    last_d   = emit ? fin : last_q;
    if (cmd_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      dx_q        <= '0;
      ndy_q       <= '0;
      down_q      <= 1'b0;
      err_q       <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_pop_o) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        end_x_q  <= end_x_d;
        end_y_q  <= end_y_d;
        dx_q     <= dx_d;
        ndy_q    <= ndy_d;
        down_q   <= down_d;
        err_q    <= err_d;
        color_q  <= color_d;
        active_q <= active_d;
        last_q   <= last_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = cur_x_q;
  assign pixel_y_o     = cur_y_q;
  assign pixel_color_o = color_q;
  assign last_o        = last_q;

  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_ctl_i.op == OP_START) |=> out_valid_q)
    else $error("start command did not produce a pixel");

  a_idle_advance_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_ctl_i.op == OP_ADVANCE && !active_q) |=> !out_valid_q)
    else $error("advance without an active line produced a pixel");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (out_valid_q && last_q))
    else $error("line ended without a final pixel");

endmodule

/* hw/rtl/bresenham_line_generator_unit.sv */
// Bresenham line generator, top level.
// Joins the front end, the command queue and the back end; depends on blg_pkg and those modules.
//
// Each input word is either a start word (tuser low), which loads two endpoints and a colour and
// gives the first pixel at once, or an advance word (tuser high), which gives the next pixel of
// the line; an advance word with no line in progress gives nothing. Endpoints are reordered so
// the walk runs left to right, and tlast marks the pixel at the far endpoint. The unit takes one
// word per cycle and gives one pixel per cycle while the output side does not stall: the back end
// does one compare and add step per pixel. A two entry command queue sits between the two sides;
// in steady flow it holds one word, so after the output side stalls the input side keeps taking
// words until the queue is full. A word passes through a queue entry and then the pixel register.
module bresenham_line_generator_unit #(
  parameter int COORD_BITS = 8,
  parameter int FIFO_DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // Fields from bit 0 up: start_x, start_y, finish_x, finish_y, pen_color, zero padding.
  input  logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata_i,
  // Fields from bit 0 up: mode.
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // Fields from bit 0 up: pixel_x, pixel_y, pixel_color, zero padding.
  output logic [((2*COORD_BITS+16+7)/8)*8-1:0] m_axis_tdata_o,
  // Fields from bit 0 up: last.
  output logic m_axis_tlast_o
);
  import blg_pkg::*;

  localparam int IN_W   = ((4*COORD_BITS+16+7)/8)*8;
  localparam int OUT_W  = ((2*COORD_BITS+16+7)/8)*8;
  localparam int DATA_W = 6*COORD_BITS + 16;
  localparam int CTL_W  = $bits(blg_cmd_ctl_t);
  localparam int CMD_W  = CTL_W + DATA_W;
  localparam int PAD_W  = OUT_W - (2*COORD_BITS + 16);

  blg_cmd_ctl_t          push_ctl, head_ctl;
  logic [DATA_W-1:0]     push_data, head_data;
  logic [CMD_W-1:0]      head_word;
  logic                  push, pop, full, empty;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [15:0]           pix_color;

  blg_front #(
    .COORD_BITS(COORD_BITS),
    .IN_W      (IN_W),
    .DATA_W    (DATA_W)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .fifo_full_i    (full),
    .push_o         (push),
    .ctl_o          (push_ctl),
    .data_o         (push_data)
  );

  blg_cmd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_ctl, push_data}),
    .pop_i  (pop),
    .rdata_o(head_word),
    .full_o (full),
    .empty_o(empty)
  );

  assign head_ctl  = blg_cmd_ctl_t'(head_word[CMD_W-1:DATA_W]);
  assign head_data = head_word[DATA_W-1:0];

  blg_back #(
    .COORD_BITS(COORD_BITS),
    .DATA_W    (DATA_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (empty),
    .cmd_ctl_i    (head_ctl),
    .cmd_data_i   (head_data),
    .cmd_pop_o    (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .pixel_x_o    (pix_x),
    .pixel_y_o    (pix_y),
    .pixel_color_o(pix_color),
    .last_o       (m_axis_tlast_o)
  );

  generate
    if (PAD_W > 0) begin : g_pad
      assign m_axis_tdata_o = {{PAD_W{1'b0}}, pix_color, pix_y, pix_x};
    end else begin : g_nopad
      assign m_axis_tdata_o = {pix_color, pix_y, pix_x};
    end
  endgenerate

endmodule
